@@ design/assert_macros.svh @@
// assertion macros shared by the decoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every rising edge outside reset
`define RC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked at every rising edge outside reset
`define RC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ design/rc_fcd_pkg.sv @@
// types, constants and helper functions of the rc frame channel decoder
package rc_fcd_pkg;

    typedef enum logic [1:0] {
        FMT_UNKNOWN = 2'd0,
        FMT_TEN     = 2'd1,
        FMT_ELEVEN  = 2'd2
    } fmt_t;

    localparam logic OP_WORD   = 1'b0;
    localparam logic OP_RESYNC = 1'b1;

    // register index, taken from paddr bit 2
    localparam logic REG_MAX_CHANNELS = 1'b0;

    localparam logic [15:0] FILLER_WORD      = 16'hffff;
    localparam logic [4:0]  MAX_CHANNELS_RST = 5'd16;
    localparam logic [2:0]  VOTE_FRAMES      = 3'd5;
    localparam logic [2:0]  FRAMES_MAX       = 3'd6;
    localparam logic [4:0]  COUNT_ODD        = 5'd13;
    localparam logic [4:0]  COUNT_REPORTED   = 5'd12;

    localparam int NUM_MASKS = 7;
    localparam logic [15:0] SET_MASKS [NUM_MASKS] = '{
        16'h003f, 16'h007f, 16'h00ff, 16'h01ff, 16'h03ff, 16'h1fff, 16'h3fff
    };

    typedef struct packed {
        logic        opcode;
        logic [15:0] raw_word;
        logic        last_of_frame;
    } item_t;

    typedef struct packed {
        logic        word_valid;
        logic [3:0]  channel_out;
        logic [11:0] value_out;
        logic        frame_done;
        logic        frame_ok;
        logic [4:0]  channel_count;
        logic [1:0]  format_state;
        logic        format_failed;
    } result_t;

    // masks are distinct, so a bitmap matches at most one
    function automatic logic mask_match(input logic [15:0] seen);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < NUM_MASKS; i++) begin
            if (seen == SET_MASKS[i]) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    function automatic logic [3:0] remap_channel(input logic [3:0] ch);
        logic [3:0] res;
        case (ch)
            4'd0:    res = 4'd2;
            4'd1:    res = 4'd0;
            4'd2:    res = 4'd1;
            default: res = ch;
        endcase
        return res;
    endfunction

    function automatic logic [4:0] count_report(input logic [4:0] c);
        return (c == COUNT_ODD) ? COUNT_REPORTED : c;
    endfunction

endpackage

@@ design/rc_fcd_scale.sv @@
// pulse width scaling: (v-1024)*1000/1700+1500, truncated toward zero
module rc_fcd_scale (
    input  logic [10:0] value_raw,
    output logic [11:0] value_us
);
    localparam logic [11:0] CENTER_US = 12'd1500;
    // 2^20/17 rounded up, exact for dividends below 2^20
    localparam logic [15:0] RECIP_17  = 16'd61681;
    localparam int          RECIP_SH  = 20;

    logic        above;
    logic [10:0] mag;
    logic [13:0] mag_x10;
    logic [29:0] prod;
    logic [9:0]  quot;

    assign above   = value_raw[10];
    assign mag     = above ? {1'b0, value_raw[9:0]} : (11'd1024 - value_raw);
    assign mag_x10 = {mag, 3'b000} + {2'b00, mag, 1'b0};
    assign prod    = {16'd0, mag_x10} * {14'd0, RECIP_17};
    assign quot    = prod[RECIP_SH +: 10];
    assign value_us = above ? (CENTER_US + {2'b00, quot}) : (CENTER_US - {2'b00, quot});

endmodule

@@ design/rc_fcd_decode.sv @@
// format guessing, lock state and per-word channel decode
`include "assert_macros.svh"

module rc_fcd_decode (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  rc_fcd_pkg::item_t  item,
    input  logic [4:0]         max_channels,
    output rc_fcd_pkg::result_t result
);
    import rc_fcd_pkg::*;

    fmt_t        format_reg, format_next;
    logic [15:0] seen_ten_reg, seen_ten_next;
    logic [15:0] seen_eleven_reg, seen_eleven_next;
    logic [2:0]  frames_reg, frames_next;
    logic [4:0]  count_reg, count_next;

    logic        is_filler;
    logic        ten_mode;
    logic [3:0]  ch;
    logic [10:0] value_raw;
    logic [11:0] value_us;
    logic        ch_ok;
    logic [4:0]  count_upd;
    logic [15:0] seen_ten_upd, seen_eleven_upd;
    logic        hit_ten, hit_eleven;
    logic        vote_now;

    assign is_filler = (item.raw_word == FILLER_WORD);
    assign ten_mode  = (format_reg == FMT_TEN);
    assign ch        = ten_mode ? item.raw_word[13:10] : item.raw_word[14:11];
    assign value_raw = ten_mode ? {item.raw_word[9:0], 1'b0} : item.raw_word[10:0];
    assign ch_ok     = !is_filler && ({1'b0, ch} < max_channels);
    assign count_upd = (ch_ok && ({1'b0, ch} >= count_reg)) ? ({1'b0, ch} + 5'd1) : count_reg;

    assign seen_ten_upd    = is_filler ? seen_ten_reg
                                       : (seen_ten_reg | (16'd1 << item.raw_word[13:10]));
    assign seen_eleven_upd = is_filler ? seen_eleven_reg
                                       : (seen_eleven_reg | (16'd1 << item.raw_word[14:11]));
    assign hit_ten    = mask_match(seen_ten_upd);
    assign hit_eleven = mask_match(seen_eleven_upd);
    assign vote_now   = item.last_of_frame && (frames_reg >= VOTE_FRAMES);

    rc_fcd_scale u_scale (
        .value_raw (value_raw),
        .value_us  (value_us)
    );

    // next state
    always_comb
    begin
        format_next      = format_reg;
        seen_ten_next    = seen_ten_reg;
        seen_eleven_next = seen_eleven_reg;
        frames_next      = frames_reg;
        count_next       = count_reg;
        if (item.opcode == OP_RESYNC) begin
            if (format_reg != FMT_UNKNOWN) begin
                format_next      = FMT_UNKNOWN;
                seen_ten_next    = '0;
                seen_eleven_next = '0;
                frames_next      = '0;
            end
            count_next = '0;
        end else begin
            unique case (format_reg)
                FMT_UNKNOWN:
                begin
                    seen_ten_next    = seen_ten_upd;
                    seen_eleven_next = seen_eleven_upd;
                    if (item.last_of_frame) begin
                        frames_next = frames_reg + 3'd1;
                        count_next  = '0;
                        if (vote_now) begin
                            if (hit_eleven && !hit_ten) begin
                                format_next = FMT_ELEVEN;
                            end else if (hit_ten && !hit_eleven) begin
                                format_next = FMT_TEN;
                            end else begin
                                seen_ten_next    = '0;
                                seen_eleven_next = '0;
                                frames_next      = '0;
                            end
                        end
                    end
                end
                default:
                begin
                    count_next = item.last_of_frame ? 5'd0 : count_upd;
                end
            endcase
        end
    end

    // result of this word
    always_comb
    begin
        result              = '0;
        result.format_state = format_next;
        if (item.opcode == OP_WORD) begin
            result.frame_done = item.last_of_frame;
            unique case (format_reg)
                FMT_UNKNOWN:
                begin
                    result.format_failed = vote_now && (hit_ten == hit_eleven);
                end
                default:
                begin
                    result.word_valid    = ch_ok;
                    result.channel_out   = ch_ok ? remap_channel(ch) : 4'd0;
                    result.value_out     = ch_ok ? value_us : 12'd0;
                    result.channel_count = count_report(count_upd);
                    result.frame_ok      = item.last_of_frame;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            format_reg      <= FMT_UNKNOWN;
            seen_ten_reg    <= '0;
            seen_eleven_reg <= '0;
            frames_reg      <= '0;
            count_reg       <= '0;
        end else if (step) begin
            format_reg      <= format_next;
            seen_ten_reg    <= seen_ten_next;
            seen_eleven_reg <= seen_eleven_next;
            frames_reg      <= frames_next;
            count_reg       <= count_next;
        end
    end

    `RC_ASSERT(a_frames_bound, frames_reg <= FRAMES_MAX, "sample count beyond six")
    `RC_ASSERT_IMPL(a_locked_no_bitmap_growth,
        step && format_reg != FMT_UNKNOWN && item.opcode == OP_WORD,
        seen_ten_next == seen_ten_reg, "bitmap changed while locked")

endmodule

@@ design/rc_frame_channel_decoder_top.sv @@
// top level of the rc frame channel decoder: input stage, register port, result stage
// Decodes 16-bit channel words of a two-format (10-bit / 11-bit) receiver frame. Each
// accepted word yields exactly one result transfer, through the input and result
// registers. One word is taken every cycle while the result register can load: a word
// sits in the input register, the decode logic between it and the result register
// updates the format state and computes the result in that cycle; a stalled result
// holds the input stage while the input register frees up when the result register
// can load. While the format is unknown, every non-filler word sets a bit in two
// channel bitmaps; the last word of the sixth frame votes them against fixed masks
// and locks the format or restarts guessing (format_failed). Once locked, channels
// at or above max_channels (register 0, byte address 0, reset 16) are dropped, and
// values are scaled to microseconds with channels 0/1/2 remapped to 2/0/1. Opcode 1
// is a resync that clears a locked format. There is no clearing pass after reset.
// Change max_channels only while no word is in flight.
`include "assert_macros.svh"

module rc_frame_channel_decoder_top (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [15:0] raw_word,
    input  logic        last_of_frame,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        word_valid,
    output logic [3:0]  channel_out,
    output logic [11:0] value_out,
    output logic        frame_done,
    output logic        frame_ok,
    output logic [4:0]  channel_count,
    output logic [1:0]  format_state,
    output logic        format_failed,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import rc_fcd_pkg::*;

    // input stage
    logic    in_full_reg, in_full_next;
    item_t   item_reg;
    // result stage
    logic    out_full_reg, out_full_next;
    result_t result_reg, result_next;
    // register file
    logic [4:0] max_ch_reg, max_ch_next;

    logic advance;
    logic step;
    logic cfg_write;

    // result register can load when empty or when its transfer completes
    assign advance  = !out_full_reg || !out_stall;
    assign step     = in_full_reg && advance;
    assign in_stall = in_full_reg && !advance;

    assign in_full_next  = (in_valid && !in_stall) ? 1'b1 : (step ? 1'b0 : in_full_reg);
    assign out_full_next = step ? 1'b1 : (out_stall ? out_full_reg : 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_full_reg  <= 1'b0;
            out_full_reg <= 1'b0;
        end else begin
            in_full_reg  <= in_full_next;
            out_full_reg <= out_full_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (!in_stall) begin
            item_reg <= '{opcode: opcode, raw_word: raw_word, last_of_frame: last_of_frame};
        end
        if (step) begin
            result_reg <= result_next;
        end
    end

    rc_fcd_decode u_decode (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (step),
        .item         (item_reg),
        .max_channels (max_ch_reg),
        .result       (result_next)
    );

    // register port, always ready, written in the access phase
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb
    begin
        max_ch_next = max_ch_reg;
        if (cfg_write && (paddr[2] == REG_MAX_CHANNELS)) begin
            max_ch_next = pwdata[4:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (paddr[2])
            REG_MAX_CHANNELS: prdata = {27'd0, max_ch_reg};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_ch_reg <= MAX_CHANNELS_RST;
        end else begin
            max_ch_reg <= max_ch_next;
        end
    end

    // result ports
    assign out_valid     = out_full_reg;
    assign word_valid    = result_reg.word_valid;
    assign channel_out   = result_reg.channel_out;
    assign value_out     = result_reg.value_out;
    assign frame_done    = result_reg.frame_done;
    assign frame_ok      = result_reg.frame_ok;
    assign channel_count = result_reg.channel_count;
    assign format_state  = result_reg.format_state;
    assign format_failed = result_reg.format_failed;

    `RC_ASSERT_IMPL(a_value_range, out_valid && word_valid,
        value_out >= 12'd898 && value_out <= 12'd2101, "scaled value out of range")
    `RC_ASSERT_IMPL(a_failed_restarts, out_valid && format_failed,
        frame_done && format_state == FMT_UNKNOWN && !frame_ok, "failed vote left a format")
    `RC_ASSERT_IMPL(a_valid_needs_lock, out_valid && word_valid,
        format_state != FMT_UNKNOWN, "channel value without a locked format")

endmodule

@@ tb/rc_frame_channel_decoder_top_tb.sv @@
// self-checking testbench of the rc frame channel decoder: directed table, then random frames
module rc_frame_channel_decoder_top_tb;
    import rc_fcd_pkg::*;

    // one row of the directed table: the word, and a typed result where it is obvious
    typedef struct packed {
        item_t   it;
        logic    has_res;
        result_t res;
    } row_t;

    localparam int      NUM_ROWS = 22;
    localparam result_t QUIET    = '0;

    // after reset, max_channels is 16
    localparam row_t DIRECTED [NUM_ROWS] = '{
        // guessing starts: plain word, resync while unknown, filler word
        '{'{OP_WORD,   16'h0000, 1'b0}, 1'b1, QUIET},
        '{'{OP_RESYNC, 16'h0000, 1'b0}, 1'b1, QUIET},
        '{'{OP_WORD,   FILLER_WORD, 1'b0}, 1'b1, QUIET},
        // six one-word frames, eleven-bit channels 0..5; the sixth casts the vote
        '{'{OP_WORD,   16'h0000, 1'b1}, 1'b0, QUIET},
        '{'{OP_WORD,   16'h0800, 1'b1}, 1'b0, QUIET},
        '{'{OP_WORD,   16'h1000, 1'b1}, 1'b0, QUIET},
        '{'{OP_WORD,   16'h1800, 1'b1}, 1'b0, QUIET},
        '{'{OP_WORD,   16'h2000, 1'b1}, 1'b0, QUIET},
        '{'{OP_WORD,   16'h2800, 1'b1}, 1'b1,
          '{1'b0, 4'd0, 12'd0, 1'b1, 1'b0, 5'd0, FMT_ELEVEN, 1'b0}},
        // locked eleven-bit: lowest and highest value, remap of 0 and 1
        '{'{OP_WORD,   16'h0000, 1'b0}, 1'b1,
          '{1'b1, 4'd2, 12'd898, 1'b0, 1'b0, 5'd1, FMT_ELEVEN, 1'b0}},
        '{'{OP_WORD,   16'h0fff, 1'b0}, 1'b1,
          '{1'b1, 4'd0, 12'd2101, 1'b0, 1'b0, 5'd2, FMT_ELEVEN, 1'b0}},
        // filler while locked, then channel 15 with the ignored top bit set
        '{'{OP_WORD,   FILLER_WORD, 1'b0}, 1'b0, QUIET},
        '{'{OP_WORD,   16'hfffe, 1'b0}, 1'b0, QUIET},
        '{'{OP_WORD,   16'h6000, 1'b1}, 1'b0, QUIET},
        // a frame whose count is 13 reports 12
        '{'{OP_WORD,   16'h6000, 1'b1}, 1'b1,
          '{1'b1, 4'd12, 12'd898, 1'b1, 1'b1, 5'd12, FMT_ELEVEN, 1'b0}},
        // resync while locked clears the format
        '{'{OP_RESYNC, 16'h0000, 1'b0}, 1'b1, QUIET},
        // six empty frames: no bitmap matches, the vote fails
        '{'{OP_WORD,   FILLER_WORD, 1'b1}, 1'b0, QUIET},
        '{'{OP_WORD,   FILLER_WORD, 1'b1}, 1'b0, QUIET},
        '{'{OP_WORD,   FILLER_WORD, 1'b1}, 1'b0, QUIET},
        '{'{OP_WORD,   FILLER_WORD, 1'b1}, 1'b0, QUIET},
        '{'{OP_WORD,   FILLER_WORD, 1'b1}, 1'b0, QUIET},
        '{'{OP_WORD,   FILLER_WORD, 1'b1}, 1'b1,
          '{1'b0, 4'd0, 12'd0, 1'b1, 1'b0, 5'd0, FMT_UNKNOWN, 1'b1}}
    };

    // channel counts of the masks, used to pick a channel set for a session
    localparam int SET_SIZES [NUM_MASKS] = '{6, 7, 8, 9, 10, 13, 14};

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        opcode;
    logic [15:0] raw_word;
    logic        last_of_frame;
    logic        out_valid;
    logic        out_stall;
    logic        word_valid;
    logic [3:0]  channel_out;
    logic [11:0] value_out;
    logic        frame_done;
    logic        frame_ok;
    logic [4:0]  channel_count;
    logic [1:0]  format_state;
    logic        format_failed;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rc_frame_channel_decoder_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .opcode        (opcode),
        .raw_word      (raw_word),
        .last_of_frame (last_of_frame),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .word_valid    (word_valid),
        .channel_out   (channel_out),
        .value_out     (value_out),
        .frame_done    (frame_done),
        .frame_ok      (frame_ok),
        .channel_count (channel_count),
        .format_state  (format_state),
        .format_failed (format_failed),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // decoder state as the block should hold it
    fmt_t        fmt_mode       = FMT_UNKNOWN;
    logic [15:0] ten_map        = '0;
    logic [15:0] eleven_map     = '0;
    logic [2:0]  sampled_frames = '0;
    logic [4:0]  run_count      = '0;
    logic [4:0]  max_cfg        = MAX_CHANNELS_RST;

    // results still owed by the block, oldest first
    result_t     pending_results [$];

    int          mismatches    = 0;
    int          words_sent    = 0;
    int          frames_ended  = 0;
    int          locks         = 0;
    int          failed_votes  = 0;
    int          values_seen   = 0;
    int          cfg_writes    = 0;
    bit          vote_failed   = 1'b0;
    bit          in_calm       = 1'b0;
    bit          out_calm      = 1'b0;

    // what the generator is steering toward in the current session
    fmt_t        tgt_fmt       = FMT_ELEVEN;
    int          tgt_n         = 7;
    bit          tgt_tie       = 1'b0;
    int          cover_idx     = 0;
    int          locked_left   = 0;

    function automatic void clear_guess();
        fmt_mode       = FMT_UNKNOWN;
        ten_map        = '0;
        eleven_map     = '0;
        sampled_frames = '0;
    endfunction

    // advances the state by one accepted word and returns the result it causes
    function automatic result_t decode_word(item_t it);
        result_t     r;
        logic [3:0]  ch;
        logic [10:0] v;
        int          hits_ten;
        int          hits_eleven;
        int          scaled;
        r = '0;
        if (it.opcode == OP_RESYNC) begin
            if (fmt_mode != FMT_UNKNOWN) begin
                clear_guess();
            end
            run_count = '0;
        end else if (fmt_mode == FMT_UNKNOWN) begin
            if (it.raw_word != FILLER_WORD) begin
                ten_map[it.raw_word[13:10]]    = 1'b1;
                eleven_map[it.raw_word[14:11]] = 1'b1;
            end
            if (it.last_of_frame) begin
                r.frame_done = 1'b1;
                frames_ended++;
                if (sampled_frames < VOTE_FRAMES) begin
                    sampled_frames = sampled_frames + 3'd1;
                end else begin
                    sampled_frames = sampled_frames + 3'd1;
                    hits_ten    = 0;
                    hits_eleven = 0;
                    for (int i = 0; i < NUM_MASKS; i++) begin
                        if (ten_map == SET_MASKS[i]) hits_ten++;
                        if (eleven_map == SET_MASKS[i]) hits_eleven++;
                    end
                    if (hits_eleven == 1 && hits_ten == 0) begin
                        fmt_mode = FMT_ELEVEN;
                        locks++;
                    end else if (hits_ten == 1 && hits_eleven == 0) begin
                        fmt_mode = FMT_TEN;
                        locks++;
                    end else begin
                        clear_guess();
                        r.format_failed = 1'b1;
                        vote_failed     = 1'b1;
                        failed_votes++;
                    end
                end
                run_count = '0;
            end
        end else begin
            // ten-bit values are doubled up front so both formats scale alike
            if (fmt_mode == FMT_TEN) begin
                ch = it.raw_word[13:10];
                v  = {it.raw_word[9:0], 1'b0};
            end else begin
                ch = it.raw_word[14:11];
                v  = it.raw_word[10:0];
            end
            if (it.raw_word != FILLER_WORD && {1'b0, ch} < max_cfg) begin
                if ({1'b0, ch} >= run_count) begin
                    run_count = {1'b0, ch} + 5'd1;
                end
                // c division truncates toward zero, as does the int division here
                scaled        = ((int'(v) - 1024) * 1000) / 1700 + 1500;
                r.word_valid  = 1'b1;
                r.value_out   = scaled[11:0];
                r.channel_out = (ch == 4'd0) ? 4'd2 :
                                (ch == 4'd1) ? 4'd0 :
                                (ch == 4'd2) ? 4'd1 : ch;
                values_seen++;
            end
            r.channel_count = (run_count == 5'd13) ? 5'd12 : run_count;
            if (it.last_of_frame) begin
                r.frame_done = 1'b1;
                r.frame_ok   = 1'b1;
                run_count    = '0;
                frames_ended++;
            end
        end
        r.format_state = fmt_mode;
        return r;
    endfunction

    // free-running clock, 10 time units
    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard stop in case the block hangs a handshake
    initial begin
        #2000000;
        $display("end of test: mismatches");
        $finish;
    end

    // one input transfer: random lead-in gap, then hold the word until it is taken
    task automatic send_item(item_t it, logic has_res, result_t res);
        int      gap;
        result_t pred;
        gap = in_calm ? 0 : $urandom_range(0, 4);
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid      <= 1'b1;
        opcode        <= it.opcode;
        raw_word      <= it.raw_word;
        last_of_frame <= it.last_of_frame;
        do @(posedge clk); while (in_stall);
        // the predictor always runs so its state tracks the block
        pred = decode_word(it);
        pending_results.push_back(has_res ? res : pred);
        words_sent++;
    endtask

    // drop valid and wait until the block owes nothing
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write max_channels, then read it back in the next transfer
    task automatic cfg_write(logic [4:0] val);
        logic [31:0] word;
        word = {27'($urandom), val};
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_MAX_CHANNELS, 2'b00};
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        max_cfg = val;
        cfg_writes++;
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[4:0] !== val) begin
            $error("max_channels: expected %0d, got %0d", val, prdata[4:0]);
            mismatches++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // channel word with random value and ignored top bits, channel in the given format
    function automatic logic [15:0] make_word(fmt_t f, logic [3:0] ch);
        logic [15:0] w;
        w = 16'($urandom);
        if (f == FMT_TEN) begin
            w[13:10] = ch;
        end else begin
            w[14:11] = ch;
        end
        return w;
    endfunction

    // pick the format and channel set the next frames aim to lock on
    function automatic void new_session();
        int kind;
        kind        = $urandom_range(0, 7);
        tgt_tie     = (kind == 0);
        tgt_fmt     = (kind < 4) ? FMT_TEN : FMT_ELEVEN;
        tgt_n       = tgt_tie ? 14 : SET_SIZES[$urandom_range(0, NUM_MASKS - 1)];
        cover_idx   = $urandom_range(0, 13);
        locked_left = $urandom_range(3, 8);
    endfunction

    // one frame of random stimulus, shaped by the format the decoder is in
    task automatic send_frame();
        int    len;
        item_t it;
        in_calm     = ($urandom_range(0, 5) == 0);
        vote_failed = 1'b0;
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 7;
        if ($urandom_range(0, 9) == 0) begin
            // noise: random words, stray resyncs, frames that may not end
            for (int i = 0; i < len; i++) begin
                it.opcode        = ($urandom_range(0, 7) == 0) ? OP_RESYNC : OP_WORD;
                it.raw_word      = 16'($urandom);
                it.last_of_frame = (i == len - 1) ? ($urandom_range(0, 3) != 0)
                                                  : ($urandom_range(0, 15) == 0);
                send_item(it, 1'b0, QUIET);
            end
        end else if (fmt_mode == FMT_UNKNOWN) begin
            // sampling frame: walk the target channel set so six frames cover it
            for (int i = 0; i < len; i++) begin
                it.opcode   = OP_WORD;
                it.raw_word = make_word(tgt_fmt, 4'(cover_idx % tgt_n));
                cover_idx++;
                // a ten-bit set of 14 channels with bit 14 low reads as 0..6 eleven-bit
                if (tgt_tie) it.raw_word[14] = 1'b0;
                if ($urandom_range(0, 19) == 0) it.raw_word = FILLER_WORD;
                it.last_of_frame = (i == len - 1);
                send_item(it, 1'b0, QUIET);
            end
            if (vote_failed) new_session();
        end else begin
            // locked frame: mostly channels of the set, some outside it, a few fillers
            for (int i = 0; i < len; i++) begin
                it.opcode   = OP_WORD;
                it.raw_word = make_word(fmt_mode,
                    4'(($urandom_range(0, 7) == 0) ? $urandom_range(0, 15)
                                                   : $urandom_range(0, tgt_n - 1)));
                if ($urandom_range(0, 14) == 0) it.raw_word = FILLER_WORD;
                it.last_of_frame = (i == len - 1);
                send_item(it, 1'b0, QUIET);
            end
            locked_left--;
            if (locked_left <= 0) begin
                it.opcode        = OP_RESYNC;
                it.raw_word      = 16'($urandom);
                it.last_of_frame = 1'($urandom);
                send_item(it, 1'b0, QUIET);
                new_session();
            end
        end
    endtask

    // result side back-pressure: a random stall before each transfer, calm stretches
    initial begin
        int gap;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            if ($urandom_range(0, 31) == 0) out_calm = !out_calm;
            gap = out_calm ? 0 : $urandom_range(0, 4);
            repeat (gap) begin
                @(negedge clk);
                out_stall <= 1'b1;
            end
            @(negedge clk);
            out_stall <= 1'b0;
            do @(posedge clk); while (!(out_valid && !out_stall));
        end
    end

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // every result transfer is matched against the oldest pending result
    always @(posedge clk) begin
        result_t want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no pending result");
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                check_field("word_valid",    16'(want.word_valid),    16'(word_valid));
                check_field("channel_out",   16'(want.channel_out),   16'(channel_out));
                check_field("value_out",     16'(want.value_out),     16'(value_out));
                check_field("frame_done",    16'(want.frame_done),    16'(frame_done));
                check_field("frame_ok",      16'(want.frame_ok),      16'(frame_ok));
                check_field("channel_count", 16'(want.channel_count), 16'(channel_count));
                check_field("format_state",  16'(want.format_state),  16'(format_state));
                check_field("format_failed", 16'(want.format_failed), 16'(format_failed));
            end
        end
    end

    // main sequence: reset, directed table, then random phases under several limits
    initial begin
        logic [4:0] cfg_plan [6];
        int         phase_end;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        opcode        = OP_WORD;
        raw_word      = '0;
        last_of_frame = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        // extremes first: above 16 drops none, 0 drops all, then 1 and 16
        cfg_plan = '{5'd31, 5'd0, 5'd1, 5'd16, 5'($urandom_range(2, 15)),
                     5'($urandom_range(0, 31))};
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed part runs with the reset value of max_channels
        for (int i = 0; i < NUM_ROWS; i++) begin
            in_calm = ($urandom_range(0, 2) == 0);
            send_item(DIRECTED[i].it, DIRECTED[i].has_res, DIRECTED[i].res);
        end

        new_session();
        for (int p = 0; p < 6; p++) begin
            // register writes only once the block has gone quiet
            settle();
            cfg_write(cfg_plan[p]);
            phase_end = words_sent + 242;
            while (words_sent < phase_end) send_frame();
        end

        settle();
        $display("covered %0d words in %0d frames, %0d max_channels writes",
                 words_sent, frames_ended, cfg_writes);
        $display("format locked %0d times, %0d votes failed, %0d channel values decoded",
                 locks, failed_votes, values_seen);
        if (mismatches == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
